// ===== src/gtg_pkg.sv =====
`timescale 1ns / 1ps

package gtg_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT,
        ST_MUL,
        ST_UPD,
        ST_EMIT
    } gtg_state_t;

    typedef enum logic [2:0] {
        REG_TURN_RATE_LIMIT  = 3'd0,
        REG_FORWARD_SPEED    = 3'd1,
        REG_HEADING_GATE     = 3'd2,
        REG_REACH_THRESHOLD  = 3'd3,
        REG_REACH_HYSTERESIS = 3'd4,
        REG_POSE_TIMEOUT     = 3'd5,
        REG_GOAL_TIMEOUT     = 3'd6,
        REG_UNUSED           = 3'd7
    } gtg_reg_idx_t;

    typedef struct packed {
        logic load;
        logic step;
        logic mul;
        logic upd;
        logic emit;
    } gtg_cmd_t;

    typedef struct packed {
        logic active_now;
        logic out_busy;
    } gtg_status_t;

    localparam int GUARD_BITS = 6;
    localparam int ZW         = 24;
    localparam int EW         = 20;
    localparam logic signed [ZW-1:0] PI_Q20     = 24'sd3294199;
    localparam logic signed [EW-1:0] TWO_PI_Q13 = 20'sd51472;
    localparam logic [15:0] GAIN_Q16 = 16'd39797;
    localparam logic [14:0] RST_TURN_RATE_LIMIT  = 15'd2458;
    localparam logic [22:0] RST_FORWARD_SPEED    = 23'd205;
    localparam logic [14:0] RST_HEADING_GATE     = 15'd4096;
    localparam logic [22:0] RST_REACH_THRESHOLD  = 23'd410;
    localparam logic [22:0] RST_REACH_HYSTERESIS = 23'd410;
    localparam logic [7:0]  RST_POSE_TIMEOUT     = 8'd40;
    localparam logic [7:0]  RST_GOAL_TIMEOUT     = 8'd100;

    function automatic logic [19:0] atan_q20(input logic [4:0] i);
        logic [19:0] v;
        case (i)
            5'd0:    v = 20'd823550;
            5'd1:    v = 20'd486170;
            5'd2:    v = 20'd256879;
            5'd3:    v = 20'd130396;
            5'd4:    v = 20'd65451;
            5'd5:    v = 20'd32757;
            5'd6:    v = 20'd16383;
            5'd7:    v = 20'd8192;
            5'd8:    v = 20'd4096;
            5'd9:    v = 20'd2048;
            5'd10:   v = 20'd1024;
            5'd11:   v = 20'd512;
            5'd12:   v = 20'd256;
            5'd13:   v = 20'd128;
            5'd14:   v = 20'd64;
            5'd15:   v = 20'd32;
            5'd16:   v = 20'd16;
            5'd17:   v = 20'd8;
            5'd18:   v = 20'd4;
            5'd19:   v = 20'd2;
            5'd20:   v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== src/go_to_goal_steering_core.sv =====
`timescale 1ns / 1ps
// Go-to-goal steering core.
// s_* stream: one transaction per control tick. s_tuser[0] flags a new pose,
//   s_tuser[1] a new goal (takes effect on the next tick). s_tdata carries
//   robot_x, robot_y, robot_yaw, goal_x, goal_y from the lowest bit up.
// m_* stream: one transaction per tick: linear_cmd and angular_cmd in m_tdata,
//   target_reached and tracking_active in m_tuser.
// cfg_*: register writes (index 0..6), always ready; write only while idle.
// Sequencing: when tracking is active, a tick passes through the CORDIC
//   micro-rotations, then the multiply, update and output states; when idle it
//   goes straight to output. One tick is in flight at a time: a new tick is
//   not accepted until the previous result has been emitted.
// Reset clears poses, goals, countdowns and the reach state, and loads the
//   register defaults. A stalled m_tready holds the result; the block may take
//   one further tick but does not present it until the held result has gone.
module go_to_goal_steering_core
    import gtg_pkg::*;
#(
    parameter int CORDIC_STEPS = 16,
    parameter int POS_WIDTH    = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // robot_x, robot_y, robot_yaw, goal_x, goal_y, zero padding
    input  logic [((4*POS_WIDTH+16+7)/8)*8-1:0] s_tdata,
    // pose_present, goal_present
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // linear_cmd, angular_cmd, zero padding
    output logic [39:0] m_tdata,
    // target_reached, tracking_active
    output logic [1:0]  m_tuser,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [22:0] cfg_data
);

    localparam int P = POS_WIDTH;

    gtg_cmd_t    cmd;
    gtg_status_t status;
    logic [4:0]  step_idx;
    logic        idle;
    logic        in_fire;
    logic [22:0] linear_cmd;
    logic signed [15:0] angular_cmd;
    logic        target_reached, tracking_active;

    assign s_tready  = idle;
    assign in_fire   = s_tvalid && idle;
    assign cfg_ready = 1'b1;

    gtg_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .status   (status),
        .cmd      (cmd),
        .step_idx (step_idx),
        .idle     (idle)
    );

    gtg_datapath #(.POS_WIDTH(POS_WIDTH)) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .step_idx        (step_idx),
        .status          (status),
        .cfg_fire        (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .pose_present    (s_tuser[0]),
        .goal_present    (s_tuser[1]),
        .robot_x         (s_tdata[P-1:0]),
        .robot_y         (s_tdata[2*P-1:P]),
        .robot_yaw       (s_tdata[2*P+15:2*P]),
        .goal_x          (s_tdata[3*P+15:2*P+16]),
        .goal_y          (s_tdata[4*P+15:3*P+16]),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .linear_cmd      (linear_cmd),
        .angular_cmd     (angular_cmd),
        .target_reached  (target_reached),
        .tracking_active (tracking_active)
    );

    assign m_tdata = {1'b0, angular_cmd, linear_cmd};
    assign m_tuser = {tracking_active, target_reached};

endmodule

// ===== src/gtg_ctrl.sv =====
`timescale 1ns / 1ps

module gtg_ctrl
    import gtg_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_fire,
    input  gtg_status_t status,
    output gtg_cmd_t    cmd,
    output logic [4:0]  step_idx,
    output logic        idle
);

    localparam int CW = $clog2(CORDIC_STEPS);

    gtg_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_fire)
                    state_next = status.active_now ? ST_ROT : ST_EMIT;
            end
            ST_ROT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(CORDIC_STEPS - 1))
                    state_next = ST_MUL;
            end
            ST_MUL:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (!status.out_busy)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        idle = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                idle     = 1'b1;
                cmd.load = in_fire;
            end
            ST_ROT:  cmd.step = 1'b1;
            ST_MUL:  cmd.mul  = 1'b1;
            ST_UPD:  cmd.upd  = 1'b1;
            ST_EMIT: cmd.emit = !status.out_busy;
            default: cmd = '0;
        endcase
    end

    assign step_idx = 5'(cnt_reg);

endmodule

// ===== src/gtg_datapath.sv =====
`timescale 1ns / 1ps

module gtg_datapath
    import gtg_pkg::*;
#(
    parameter int POS_WIDTH = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  gtg_cmd_t                    cmd,
    input  logic [4:0]                  step_idx,
    output gtg_status_t                 status,
    input  logic                        cfg_fire,
    input  logic [2:0]                  cfg_index,
    input  logic [22:0]                 cfg_data,
    input  logic                        pose_present,
    input  logic                        goal_present,
    input  logic signed [POS_WIDTH-1:0] robot_x,
    input  logic signed [POS_WIDTH-1:0] robot_y,
    input  logic signed [15:0]          robot_yaw,
    input  logic signed [POS_WIDTH-1:0] goal_x,
    input  logic signed [POS_WIDTH-1:0] goal_y,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [22:0]                 linear_cmd,
    output logic signed [15:0]          angular_cmd,
    output logic                        target_reached,
    output logic                        tracking_active
);

    localparam int W  = POS_WIDTH + 10;
    localparam int DW = POS_WIDTH + 1;
    localparam int PW = W - 1 + 16;

    logic [14:0] turn_rate_limit_reg;
    logic [22:0] forward_speed_reg;
    logic [14:0] heading_gate_reg;
    logic [22:0] reach_threshold_reg;
    logic [22:0] reach_hysteresis_reg;
    logic [7:0]  pose_timeout_reg;
    logic [7:0]  goal_timeout_reg;

    logic signed [POS_WIDTH-1:0] robot_x_reg, robot_y_reg, goal_x_reg, goal_y_reg;
    logic signed [15:0]          yaw_reg;
    logic [7:0]                  pose_cd_reg, goal_cd_reg;
    logic [24:0]                 last_dist_reg;
    logic signed [EW-1:0]        last_err_reg;
    logic [23:0]                 thresh_reg;
    logic                        reached_reg;
    logic                        active_reg;
    logic                        zero_reg;

    logic signed [W-1:0]  x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic [PW-1:0]        prod_reg;

    logic                  out_valid_reg;
    logic [22:0]           lin_reg;
    logic signed [15:0]    ang_reg;
    logic                  reached_out_reg;
    logic                  active_out_reg;

    // Tick front end
    logic [7:0]                  pose_cd_pre, pose_cd_dec, goal_cd_dec;
    logic signed [POS_WIDTH-1:0] px, py;
    logic signed [DW-1:0]        dx, dy;
    logic signed [W-1:0]         x0, y0;

    always_comb
    begin
        pose_cd_pre = pose_present ? pose_timeout_reg : pose_cd_reg;
        pose_cd_dec = (pose_cd_pre != 8'd0) ? pose_cd_pre - 8'd1 : 8'd0;
        goal_cd_dec = (goal_cd_reg != 8'd0) ? goal_cd_reg - 8'd1 : 8'd0;
        px = pose_present ? robot_x : robot_x_reg;
        py = pose_present ? robot_y : robot_y_reg;
        dx = DW'(goal_x_reg) - DW'(px);
        dy = DW'(goal_y_reg) - DW'(py);
        x0 = W'(dx) <<< GUARD_BITS;
        y0 = W'(dy) <<< GUARD_BITS;
    end

    assign status.active_now = (pose_cd_dec != 8'd0) && (goal_cd_dec > 8'd1);
    assign status.out_busy   = out_valid_reg && !out_ready;

    // CORDIC micro-rotation
    logic signed [W-1:0] xs, ys;
    logic signed [ZW-1:0] at;
    always_comb
    begin
        xs = x_reg >>> step_idx;
        ys = y_reg >>> step_idx;
        at = ZW'(signed'({1'b0, atan_q20(step_idx)}));
    end

    // Distance and heading error
    logic [W-2:0]        xpos;
    logic [63:0]         rnd;
    logic [24:0]         range_q;
    logic signed [ZW:0]  zr;
    logic signed [EW-1:0] bearing, err, alt, aerr, aalt;
    always_comb
    begin
        xpos = x_reg[W-1] ? '0 : x_reg[W-2:0];
        rnd  = (64'(prod_reg) + 64'd2097152) >> 22;
        range_q = (rnd > 64'h1FFFFFF) ? 25'h1FFFFFF : rnd[24:0];
        zr   = (ZW+1)'(z_reg) + (ZW+1)'(64);
        bearing = EW'(zr >>> 7);
        if (zero_reg)
        begin
            range_q = '0;
            bearing = '0;
        end
        err  = bearing - EW'(yaw_reg);
        alt  = (err > 0) ? err - TWO_PI_Q13 : err + TWO_PI_Q13;
        aerr = (err < 0) ? -err : err;
        aalt = (alt < 0) ? -alt : alt;
        if (aalt < aerr)
            err = alt;
    end

    // Commands
    logic signed [EW-1:0] lim, ae, angc;
    logic [22:0]          lin;
    logic signed [15:0]   ang;
    logic                 reach_now;
    always_comb
    begin
        lim  = EW'(signed'({1'b0, turn_rate_limit_reg}));
        ae   = (last_err_reg < 0) ? -last_err_reg : last_err_reg;
        angc = last_err_reg;
        if (angc > lim)
            angc = lim;
        if (angc < -lim)
            angc = -lim;
        lin = '0;
        ang = '0;
        if (active_reg && !reached_reg)
        begin
            lin = (ae < EW'(signed'({1'b0, heading_gate_reg}))) ? forward_speed_reg : '0;
            ang = angc[15:0];
        end
        reach_now = last_dist_reg < 25'(thresh_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_rate_limit_reg  <= RST_TURN_RATE_LIMIT;
            forward_speed_reg    <= RST_FORWARD_SPEED;
            heading_gate_reg     <= RST_HEADING_GATE;
            reach_threshold_reg  <= RST_REACH_THRESHOLD;
            reach_hysteresis_reg <= RST_REACH_HYSTERESIS;
            pose_timeout_reg     <= RST_POSE_TIMEOUT;
            goal_timeout_reg     <= RST_GOAL_TIMEOUT;
            robot_x_reg   <= '0;
            robot_y_reg   <= '0;
            yaw_reg       <= '0;
            goal_x_reg    <= '0;
            goal_y_reg    <= '0;
            pose_cd_reg   <= '0;
            goal_cd_reg   <= '0;
            last_dist_reg <= '0;
            last_err_reg  <= '0;
            thresh_reg    <= 24'(RST_REACH_THRESHOLD);
            reached_reg   <= 1'b0;
            active_reg    <= 1'b0;
            zero_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                case (gtg_reg_idx_t'(cfg_index))
                    REG_TURN_RATE_LIMIT:  turn_rate_limit_reg  <= cfg_data[14:0];
                    REG_FORWARD_SPEED:    forward_speed_reg    <= cfg_data;
                    REG_HEADING_GATE:     heading_gate_reg     <= cfg_data[14:0];
                    REG_REACH_THRESHOLD:  reach_threshold_reg  <= cfg_data;
                    REG_REACH_HYSTERESIS: reach_hysteresis_reg <= cfg_data;
                    REG_POSE_TIMEOUT:     pose_timeout_reg     <= cfg_data[7:0];
                    REG_GOAL_TIMEOUT:     goal_timeout_reg     <= cfg_data[7:0];
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                if (pose_present)
                begin
                    robot_x_reg <= robot_x;
                    robot_y_reg <= robot_y;
                    yaw_reg     <= robot_yaw;
                end
                if (goal_present)
                begin
                    goal_x_reg  <= goal_x;
                    goal_y_reg  <= goal_y;
                    goal_cd_reg <= goal_timeout_reg;
                end
                else
                    goal_cd_reg <= goal_cd_dec;
                pose_cd_reg <= pose_cd_dec;
                active_reg  <= status.active_now;
                zero_reg    <= (dx == '0) && (dy == '0);
            end
            if (cmd.upd)
            begin
                last_dist_reg <= range_q;
                last_err_reg  <= err;
            end
            if (cmd.emit)
            begin
                reached_reg <= reach_now;
                thresh_reg  <= reach_now ? 24'(reach_threshold_reg) + 24'(reach_hysteresis_reg)
                                         : 24'(reach_threshold_reg);
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (dx < 0)
            begin
                x_reg <= -x0;
                y_reg <= -y0;
                z_reg <= (dy >= 0) ? PI_Q20 : -PI_Q20;
            end
            else
            begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
        end
        else if (cmd.step)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end
        end
        if (cmd.mul)
            prod_reg <= PW'(xpos) * PW'(GAIN_Q16);
        if (cmd.emit)
        begin
            lin_reg         <= lin;
            ang_reg         <= ang;
            reached_out_reg <= reach_now;
            active_out_reg  <= active_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign linear_cmd      = lin_reg;
    assign angular_cmd     = ang_reg;
    assign target_reached  = reached_out_reg;
    assign tracking_active = active_out_reg;

endmodule

// ===== src/gtg_checker.sv =====
`timescale 1ns / 1ps

module gtg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction accepted while busy");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    a_idle_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[1]) |-> (m_tdata[38:0] == 39'd0))
        else $error("command while not tracking");

    a_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |-> ##1 !m_tvalid || !$past(m_tvalid) || $past(m_tready) == 1'b0)
        else $error("result raised at accept");

endmodule

bind go_to_goal_steering_core gtg_checker u_gtg_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
